// ----- rtl/ptd_pkg.sv -----
// shared constants for the trial division primality tester
package ptd_pkg;

    // default candidate width in bits
    localparam int NUM_WIDTH_DEF = 16;

    // smallest divisor tried, also the smallest prime
    localparam int FIRST_DIVISOR = 2;

endpackage

// ----- rtl/prime_trial_division.sv -----
// Trial division primality tester. Each input beat carries one unsigned candidate of NUM_WIDTH
// bits; one output beat follows with is_prime set when the candidate is prime. Zero and one
// answer not prime, two and three answer prime without any division. Larger candidates are
// divided by d = 2, 3, 4, ... in one shared restoring divider that retires one quotient bit
// per cycle. The search stops at the first exact divisor, or as soon as the quotient
// drops below d, which means d * d exceeds the candidate. Composites finish at their
// smallest factor. The block takes one candidate at a time: s_ready is high only while
// the divider is idle. The answer sits in an output register, so a new candidate is
// taken while it waits.
module prime_trial_division #(
    parameter int NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [NUM_WIDTH-1:0] s_candidate,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_prime
);
    import ptd_pkg::*;

    localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_TEST = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [NUM_WIDTH-1:0] num_reg, num_next;
    logic [NUM_WIDTH-1:0] div_reg, div_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 ans_reg, ans_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_is_prime_reg, m_is_prime_next;

    logic [NUM_WIDTH:0]   shifted;
    logic [NUM_WIDTH:0]   trial;
    logic                 fits;
    logic                 out_free;

    // one restoring division step
    assign shifted = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        num_next        = num_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        ans_next        = ans_reg;
        m_valid_next    = m_valid_reg;
        m_is_prime_next = m_is_prime_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    num_next = s_candidate;
                    div_next = NUM_WIDTH'(FIRST_DIVISOR);
                    rem_next = '0;
                    quo_next = s_candidate;
                    cnt_next = CNT_W'(NUM_WIDTH - 1);
                    priority if (s_candidate < NUM_WIDTH'(FIRST_DIVISOR)) begin
                        ans_next   = 1'b0;
                        state_next = ST_HOLD;
                    end else if (s_candidate < NUM_WIDTH'(FIRST_DIVISOR * FIRST_DIVISOR)) begin
                        ans_next   = 1'b1;
                        state_next = ST_HOLD;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next = fits ? trial[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                // exact divisor, or d squared above the candidate, or try the next d
                priority if (rem_reg == '0) begin
                    ans_next   = 1'b0;
                    state_next = ST_HOLD;
                end else if (quo_reg < div_reg) begin
                    ans_next   = 1'b1;
                    state_next = ST_HOLD;
                end else begin
                    div_next   = div_reg + NUM_WIDTH'(1);
                    rem_next   = '0;
                    quo_next   = num_reg;
                    cnt_next   = CNT_W'(NUM_WIDTH - 1);
                    state_next = ST_DIV;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_is_prime_next = ans_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        num_reg        <= num_next;
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        ans_reg        <= ans_next;
        m_is_prime_reg <= m_is_prime_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;

endmodule

// ----- rtl/ptd_checker.sv -----
// port level checks for the trial division primality tester, bound to its top level
module ptd_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_is_prime
);

    // a stalled result beat holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_prime))
        else $error("result beat changed while stalled");

    // a candidate beat makes the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after a candidate beat");

    // a new result appears only as a search finishes
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result beat without a search in progress");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind prime_trial_division ptd_checker u_ptd_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_is_prime (m_is_prime)
);
